// ----- sv/ncs_pkg.sv -----
`timescale 1ns / 1ps

package ncs_pkg;

  // Sine table geometry. Only a quarter wave plus its end point is stored.
  localparam int SINE_TABLE_DEPTH = 1024;
  localparam int SINE_AW          = $clog2(SINE_TABLE_DEPTH);
  localparam int SINE_QUARTER     = SINE_TABLE_DEPTH / 4;
  localparam int SINE_QW          = SINE_AW - 1;
  localparam int SINE_VAL_W       = 15;
  localparam int SINE_W           = 16;

  // Field and state widths.
  localparam int CFG_W       = 32;
  localparam int CFG_IDX_W   = 3;
  localparam int COUNT_W     = 20;
  localparam int SEED_W      = 32;
  localparam int GAIN_W      = 16;
  localparam int PSTEP_W     = 31;
  localparam int PHASE_W     = 32;
  localparam int SWEEP_W     = 16;
  localparam int DFAC_W      = 24;
  localparam int ATK_W       = 17;
  localparam int LP_W        = 24;
  localparam int DIFF_W      = 25;
  localparam int DECAY_W     = 25;
  localparam int ENV_W       = 25;
  localparam int MIX_W       = 26;
  localparam int SAMPLE_W    = 16;
  localparam int Q_W         = 15;
  localparam int MAG_W       = 48;

  // Shared multiplier: signed A times signed B, full-width product.
  localparam int MUL_A_W     = 33;
  localparam int MUL_B_W     = 26;
  localparam int ACC_W       = MUL_A_W + MUL_B_W;

  // Fixed-point shifts.
  localparam int LP_SHIFT    = 16;
  localparam int ENV_SHIFT   = 16;
  localparam int MIX_SHIFT   = 16;
  localparam int DECAY_SHIFT = 24;
  localparam int CLAMP_SHIFT = 47;
  localparam int SCALE_SPLIT = 24;
  localparam int Q_SHIFT     = CLAMP_SHIFT - SCALE_SPLIT;

  // Arithmetic constants.
  localparam logic [31:0] LCG_MUL      = 32'd1664525;
  localparam logic [31:0] LCG_ADD      = 32'd1013904223;
  localparam logic [31:0] MIX_NOISE_K  = 32'd157286;
  localparam logic [31:0] MIX_SINE_K   = 32'd39322 * 32'd256;
  localparam logic [31:0] SCALE_K      = 32'd32000;
  localparam logic [DECAY_W-1:0] ONE_Q24 = DECAY_W'(1) << 24;
  localparam logic [ATK_W-1:0]   ONE_Q16 = ATK_W'(1) << 16;
  localparam logic [63:0] HALF_PI_Q30  = 64'd1686629713;

  // Register reset values.
  localparam logic [COUNT_W-1:0] RST_SAMPLE_COUNT = 20'd70560;
  localparam logic [SEED_W-1:0]  RST_NOISE_SEED   = 32'd1;
  localparam logic [GAIN_W-1:0]  RST_LOWPASS_GAIN = 16'd7864;
  localparam logic [PSTEP_W-1:0] RST_START_STEP   = 31'd4674794;
  localparam logic [SWEEP_W-1:0] RST_SWEEP_STEP   = 16'd33;
  localparam logic [DFAC_W-1:0]  RST_DECAY_FACTOR = 24'd16776075;
  localparam logic [ATK_W-1:0]   RST_ATTACK_STEP  = 17'd594;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SAMPLE_COUNT = 3'd0,
    CFG_NOISE_SEED   = 3'd1,
    CFG_LOWPASS_GAIN = 3'd2,
    CFG_START_STEP   = 3'd3,
    CFG_SWEEP_STEP   = 3'd4,
    CFG_DECAY_FACTOR = 3'd5,
    CFG_ATTACK_STEP  = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    logic [COUNT_W-1:0] sample_count;
    logic [SEED_W-1:0]  noise_seed;
    logic [GAIN_W-1:0]  lowpass_gain;
    logic [PSTEP_W-1:0] start_phase_step;
    logic [SWEEP_W-1:0] sweep_step;
    logic [DFAC_W-1:0]  decay_factor;
    logic [ATK_W-1:0]   attack_step;
  } cfg_t;

  typedef enum logic [2:0] {
    A_NOISE, A_DECAY, A_DIFF, A_SINE, A_LP, A_MIX, A_MAG_LO, A_MAG_HI
  } a_sel_t;

  typedef enum logic [2:0] {
    B_LCG, B_ATTACK, B_DECAY, B_GAIN, B_SINE_K, B_NOISE_K, B_ENV, B_SCALE
  } b_sel_t;

  typedef enum logic [1:0] {
    ACC_HOLD, ACC_LOAD, ACC_ADD, ACC_SHR_ADD
  } acc_mode_t;

  typedef struct packed {
    logic      reload;
    logic      phase_adv;
    logic      noise_wr;
    logic      sine_wr;
    logic      env_wr;
    logic      diff_wr;
    logic      decay_wr;
    logic      lp_wr;
    logic      mag_wr;
    logic      step_upd;
    logic      res_wr;
    logic      done;
    a_sel_t    a_sel;
    b_sel_t    b_sel;
    acc_mode_t acc_mode;
  } ctrl_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last;
  } res_t;

  typedef logic [SINE_VAL_W-1:0] quarter_rom_t [SINE_QUARTER+1];

  // Quarter-wave sine magnitude in Q1.15, from a Taylor series in Q30.
  function automatic quarter_rom_t build_sine_quarter();
    quarter_rom_t      rom;
    logic [63:0]        r;
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic [63:0]        vq;
    logic signed [63:0] sum;
    for (int j = 0; j <= SINE_QUARTER; j++) begin
      r    = 64'(j) << (32 - SINE_AW);
      x    = (r * HALF_PI_Q30) >> 30;
      x2   = (x * x) >> 30;
      term = x;
      sum  = $signed(x);
      term = ((term * x2) >> 30) / 64'd6;
      sum  = sum - $signed(term);
      term = ((term * x2) >> 30) / 64'd20;
      sum  = sum + $signed(term);
      term = ((term * x2) >> 30) / 64'd42;
      sum  = sum - $signed(term);
      term = ((term * x2) >> 30) / 64'd72;
      sum  = sum + $signed(term);
      term = ((term * x2) >> 30) / 64'd110;
      sum  = sum - $signed(term);
      term = ((term * x2) >> 30) / 64'd156;
      sum  = sum + $signed(term);
      if (sum < 0) begin
        sum = '0;
      end
      vq = ($unsigned(sum) + 64'd16384) >> 15;
      if (vq > 64'd32767) begin
        vq = 64'd32767;
      end
      rom[j] = vq[SINE_VAL_W-1:0];
    end
    return rom;
  endfunction

  localparam quarter_rom_t SINE_QUARTER_ROM = build_sine_quarter();

endpackage

// ----- sv/ncs_mul.sv -----
`timescale 1ns / 1ps

module ncs_mul import ncs_pkg::*; (
  input  logic                     clk,
  input  acc_mode_t                mode,
  input  logic signed [MUL_A_W-1:0] a,
  input  logic signed [MUL_B_W-1:0] b,
  output logic signed [ACC_W-1:0]   acc
);

  logic signed [ACC_W-1:0] prod;

  assign prod = ACC_W'(a) * ACC_W'(b);

  // The shifted add lets a wide product be built from two narrow halves.
  always_ff @(posedge clk) begin
    case (mode)
      ACC_LOAD:    acc <= prod;
      ACC_ADD:     acc <= acc + prod;
      ACC_SHR_ADD: acc <= (acc >>> SCALE_SPLIT) + prod;
      default:     acc <= acc;
    endcase
  end

endmodule

// ----- sv/ncs_seq.sv -----
`timescale 1ns / 1ps

module ncs_seq import ncs_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  cmd_valid,
  input  logic  restart,
  input  logic  ended,
  input  logic  res_free,
  output logic  cmd_ready,
  output ctrl_t ctrl
);

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_LCG, S_NOISE, S_ENV, S_LOWPASS, S_SINE, S_MIXLP,
    S_SHAPE, S_CLAMP, S_SCALE_LO, S_SCALE_HI, S_OUT
  } state_t;

  state_t state;
  logic   done_flag;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      done_flag <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          done_flag <= ended;
          state     <= ended ? S_OUT : S_LCG;
        end
        S_LCG:      state <= S_NOISE;
        S_NOISE:    state <= S_ENV;
        S_ENV:      state <= S_LOWPASS;
        S_LOWPASS:  state <= S_SINE;
        S_SINE:     state <= S_MIXLP;
        S_MIXLP:    state <= S_SHAPE;
        S_SHAPE:    state <= S_CLAMP;
        S_CLAMP:    state <= S_SCALE_LO;
        S_SCALE_LO: state <= S_SCALE_HI;
        S_SCALE_HI: state <= S_OUT;
        S_OUT: begin
          if (res_free) begin
            state <= S_IDLE;
          end
        end
        default:    state <= S_IDLE;
      endcase
    end
  end

  assign cmd_ready = (state == S_IDLE);

  always_comb begin
    ctrl          = '0;
    ctrl.a_sel    = A_NOISE;
    ctrl.b_sel    = B_LCG;
    ctrl.acc_mode = ACC_HOLD;
    case (state)
      S_IDLE: ctrl.reload = cmd_valid & restart;
      S_LCG: begin
        ctrl.phase_adv = 1'b1;
        ctrl.a_sel     = A_NOISE;
        ctrl.b_sel     = B_LCG;
        ctrl.acc_mode  = ACC_LOAD;
      end
      S_NOISE: begin
        ctrl.noise_wr = 1'b1;
        ctrl.sine_wr  = 1'b1;
        ctrl.a_sel    = A_DECAY;
        ctrl.b_sel    = B_ATTACK;
        ctrl.acc_mode = ACC_LOAD;
      end
      S_ENV: begin
        ctrl.env_wr   = 1'b1;
        ctrl.diff_wr  = 1'b1;
        ctrl.a_sel    = A_DECAY;
        ctrl.b_sel    = B_DECAY;
        ctrl.acc_mode = ACC_LOAD;
      end
      S_LOWPASS: begin
        ctrl.decay_wr = 1'b1;
        ctrl.a_sel    = A_DIFF;
        ctrl.b_sel    = B_GAIN;
        ctrl.acc_mode = ACC_LOAD;
      end
      S_SINE: begin
        ctrl.lp_wr    = 1'b1;
        ctrl.a_sel    = A_SINE;
        ctrl.b_sel    = B_SINE_K;
        ctrl.acc_mode = ACC_LOAD;
      end
      S_MIXLP: begin
        ctrl.a_sel    = A_LP;
        ctrl.b_sel    = B_NOISE_K;
        ctrl.acc_mode = ACC_ADD;
      end
      S_SHAPE: begin
        ctrl.a_sel    = A_MIX;
        ctrl.b_sel    = B_ENV;
        ctrl.acc_mode = ACC_LOAD;
      end
      S_CLAMP: ctrl.mag_wr = 1'b1;
      S_SCALE_LO: begin
        ctrl.a_sel    = A_MAG_LO;
        ctrl.b_sel    = B_SCALE;
        ctrl.acc_mode = ACC_LOAD;
      end
      S_SCALE_HI: begin
        ctrl.a_sel    = A_MAG_HI;
        ctrl.b_sel    = B_SCALE;
        ctrl.acc_mode = ACC_SHR_ADD;
      end
      S_OUT: begin
        ctrl.res_wr   = res_free;
        ctrl.step_upd = res_free & ~done_flag;
        ctrl.done     = done_flag;
      end
      default: ;
    endcase
  end

endmodule

// ----- sv/ncs_dp.sv -----
`timescale 1ns / 1ps

module ncs_dp import ncs_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  cfg_t                      cfg,
  input  ctrl_t                     ctrl,
  input  logic signed [ACC_W-1:0]   acc,
  output logic signed [MUL_A_W-1:0] mul_a,
  output logic signed [MUL_B_W-1:0] mul_b,
  output logic                      ended,
  output res_t                      res
);

  localparam logic signed [ACC_W-1:0] V_MAX = ACC_W'(64'd1 << CLAMP_SHIFT);
  localparam logic signed [ACC_W-1:0] V_MIN = -V_MAX;

  // Sound state.
  logic [SEED_W-1:0]         noise_state;
  logic signed [LP_W-1:0]    lowpass_level;
  logic [PHASE_W-1:0]        osc_phase;
  logic [PSTEP_W-1:0]        current_phase_step;
  logic [DECAY_W-1:0]        decay_level;
  logic [ATK_W-1:0]          attack_level;
  logic [COUNT_W-1:0]        sample_index;

  // Per-sample intermediates.
  logic signed [SINE_W-1:0]  sine;
  logic [ENV_W-1:0]          env;
  logic signed [DIFF_W-1:0]  diff;
  logic [MAG_W-1:0]          mag;
  logic                      neg;

  logic signed [LP_W-1:0]    noise;
  logic signed [LP_W-1:0]    lp_next;
  logic signed [MIX_W-1:0]   mix;
  logic signed [ACC_W-1:0]   v_clamped;
  logic signed [ACC_W-1:0]   v_abs;
  logic [SINE_AW-1:0]        sine_idx;
  logic [SINE_QW-1:0]        quarter_idx;
  logic [SINE_W-1:0]         sine_mag;
  logic signed [SINE_W-1:0]  sine_val;
  logic [ATK_W:0]            attack_sum;
  logic [ATK_W-1:0]          attack_next;
  logic [PSTEP_W-1:0]        pstep_next;
  logic [SAMPLE_W-1:0]       q_ext;

  assign noise   = {~noise_state[SEED_W-1], noise_state[SEED_W-2 -: LP_W-1]};
  assign lp_next = lowpass_level + $signed(acc[LP_SHIFT +: LP_W]);
  assign mix     = $signed(acc[MIX_SHIFT +: MIX_W]);

  // Quadrant folding onto the quarter-wave table.
  assign sine_idx    = osc_phase[PHASE_W-1 -: SINE_AW];
  assign quarter_idx = sine_idx[SINE_AW-2]
                       ? SINE_QW'(SINE_QUARTER) - {1'b0, sine_idx[SINE_AW-3:0]}
                       : {1'b0, sine_idx[SINE_AW-3:0]};
  assign sine_mag    = {1'b0, SINE_QUARTER_ROM[quarter_idx]};
  assign sine_val    = sine_idx[SINE_AW-1] ? -$signed(sine_mag) : $signed(sine_mag);

  always_comb begin
    if (acc > V_MAX) begin
      v_clamped = V_MAX;
    end else if (acc < V_MIN) begin
      v_clamped = V_MIN;
    end else begin
      v_clamped = acc;
    end
    v_abs = (v_clamped < 0) ? -v_clamped : v_clamped;
  end

  assign attack_sum  = {1'b0, attack_level} + {1'b0, cfg.attack_step};
  assign attack_next = (attack_sum > {1'b0, ONE_Q16}) ? ONE_Q16 : attack_sum[ATK_W-1:0];
  assign pstep_next  = (current_phase_step > PSTEP_W'(cfg.sweep_step))
                       ? current_phase_step - PSTEP_W'(cfg.sweep_step) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      noise_state        <= RST_NOISE_SEED;
      lowpass_level      <= '0;
      osc_phase          <= '0;
      current_phase_step <= RST_START_STEP;
      decay_level        <= ONE_Q24;
      attack_level       <= '0;
      sample_index       <= '0;
    end else if (ctrl.reload) begin
      noise_state        <= cfg.noise_seed;
      lowpass_level      <= '0;
      osc_phase          <= '0;
      current_phase_step <= cfg.start_phase_step;
      decay_level        <= ONE_Q24;
      attack_level       <= '0;
      sample_index       <= '0;
    end else begin
      if (ctrl.phase_adv) begin
        osc_phase <= osc_phase + PHASE_W'(current_phase_step);
      end
      if (ctrl.noise_wr) begin
        noise_state <= acc[SEED_W-1:0] + LCG_ADD;
      end
      if (ctrl.decay_wr) begin
        decay_level <= acc[DECAY_SHIFT +: DECAY_W];
      end
      if (ctrl.lp_wr) begin
        lowpass_level <= lp_next;
      end
      if (ctrl.step_upd) begin
        current_phase_step <= pstep_next;
        attack_level       <= attack_next;
        sample_index       <= sample_index + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.sine_wr) begin
      sine <= sine_val;
    end
    if (ctrl.env_wr) begin
      env <= acc[ENV_SHIFT +: ENV_W];
    end
    if (ctrl.diff_wr) begin
      diff <= DIFF_W'(noise) - DIFF_W'(lowpass_level);
    end
    if (ctrl.mag_wr) begin
      mag <= v_abs[MAG_W-1:0];
      neg <= (acc < 0);
    end
  end

  always_comb begin
    case (ctrl.a_sel)
      A_NOISE:  mul_a = MUL_A_W'(noise_state);
      A_DECAY:  mul_a = MUL_A_W'(decay_level);
      A_DIFF:   mul_a = MUL_A_W'(diff);
      A_SINE:   mul_a = MUL_A_W'(sine);
      A_LP:     mul_a = MUL_A_W'(lowpass_level);
      A_MIX:    mul_a = MUL_A_W'(mix);
      A_MAG_LO: mul_a = MUL_A_W'(mag[SCALE_SPLIT-1:0]);
      A_MAG_HI: mul_a = MUL_A_W'(mag[MAG_W-1:SCALE_SPLIT]);
      default:  mul_a = '0;
    endcase
    case (ctrl.b_sel)
      B_LCG:     mul_b = MUL_B_W'(LCG_MUL);
      B_ATTACK:  mul_b = MUL_B_W'(attack_level);
      B_DECAY:   mul_b = MUL_B_W'(cfg.decay_factor);
      B_GAIN:    mul_b = MUL_B_W'(cfg.lowpass_gain);
      B_SINE_K:  mul_b = MUL_B_W'(MIX_SINE_K);
      B_NOISE_K: mul_b = MUL_B_W'(MIX_NOISE_K);
      B_ENV:     mul_b = MUL_B_W'(env);
      B_SCALE:   mul_b = MUL_B_W'(SCALE_K);
      default:   mul_b = '0;
    endcase
  end

  assign ended    = (sample_index >= cfg.sample_count);
  assign q_ext    = {1'b0, acc[Q_SHIFT +: Q_W]};
  assign res.sample = neg ? -$signed(q_ext) : $signed(q_ext);
  assign res.last   = (({1'b0, sample_index} + 1'b1) == {1'b0, cfg.sample_count});

endmodule

// ----- sv/noise_chirp_sound_synth.sv -----
`timescale 1ns / 1ps
// Sound-effect synthesizer: lowpassed noise plus a downward sine chirp under an
// attack/decay envelope, one 16-bit sample per command word.
// Command channel (cmd_valid/cmd_ready, field restart): restart=1 reloads the
// sound state and returns sample zero; restart=0 returns the next sample.
// Result channel (res_valid/res_ready, fields sample, last, done_res): last
// marks the final sample of the sound; after that, words carry done_res=1 and
// a zero sample and leave the state untouched.
// A running sample steps through the check, LCG, noise, envelope, lowpass, sine,
// mix, shape, clamp, scale-low and scale-high states and then output; an ended
// sound goes from the check straight to output. The one shared multiplier forms
// all nine products of a sample in turn, so a new command waits for the output.
// The result sits in an output register, so a finished word may wait there
// while the next command is already being worked on; if the receiver stalls,
// the following word holds in its last step until the register frees up.
// Configuration writes (cfg_we, cfg_index, cfg_data) are registered. The
// seed and start step apply at the next restart; the rest are used live.
// Synchronous reset loads the default registers and the reloaded sound state.
module noise_chirp_sound_synth import ncs_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_W-1:0]           cfg_data,
  input  logic                       cmd_valid,
  output logic                       cmd_ready,
  input  logic                       restart,
  output logic                       res_valid,
  input  logic                       res_ready,
  output logic signed [SAMPLE_W-1:0] sample,
  output logic                       last,
  output logic                       done_res
);

  cfg_t                      cfg;
  ctrl_t                     ctrl;
  res_t                      res;
  logic                      ended;
  logic                      res_free;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [ACC_W-1:0]   acc;

  // Configuration registers. Unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sample_count     <= RST_SAMPLE_COUNT;
      cfg.noise_seed       <= RST_NOISE_SEED;
      cfg.lowpass_gain     <= RST_LOWPASS_GAIN;
      cfg.start_phase_step <= RST_START_STEP;
      cfg.sweep_step       <= RST_SWEEP_STEP;
      cfg.decay_factor     <= RST_DECAY_FACTOR;
      cfg.attack_step      <= RST_ATTACK_STEP;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_SAMPLE_COUNT: cfg.sample_count     <= cfg_data[COUNT_W-1:0];
        CFG_NOISE_SEED:   cfg.noise_seed       <= cfg_data[SEED_W-1:0];
        CFG_LOWPASS_GAIN: cfg.lowpass_gain     <= cfg_data[GAIN_W-1:0];
        CFG_START_STEP:   cfg.start_phase_step <= cfg_data[PSTEP_W-1:0];
        CFG_SWEEP_STEP:   cfg.sweep_step       <= cfg_data[SWEEP_W-1:0];
        CFG_DECAY_FACTOR: cfg.decay_factor     <= cfg_data[DFAC_W-1:0];
        CFG_ATTACK_STEP:  cfg.attack_step      <= cfg_data[ATK_W-1:0];
        default: ;
      endcase
    end
  end

  // The output register is free when empty or being drained this cycle.
  assign res_free = ~res_valid | res_ready;

  ncs_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .restart   (restart),
    .ended     (ended),
    .res_free  (res_free),
    .cmd_ready (cmd_ready),
    .ctrl      (ctrl)
  );

  ncs_dp u_dp (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg),
    .ctrl  (ctrl),
    .acc   (acc),
    .mul_a (mul_a),
    .mul_b (mul_b),
    .ended (ended),
    .res   (res)
  );

  ncs_mul u_mul (
    .clk  (clk),
    .mode (ctrl.acc_mode),
    .a    (mul_a),
    .b    (mul_b),
    .acc  (acc)
  );

  // Output word register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (ctrl.res_wr) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.res_wr) begin
      sample   <= ctrl.done ? '0 : res.sample;
      last     <= ~ctrl.done & res.last;
      done_res <= ctrl.done;
    end
  end

endmodule

// ----- sv/ncs_checker.sv -----
`timescale 1ns / 1ps

module ncs_checker import ncs_pkg::*; (
  input logic                       clk,
  input logic                       rst,
  input logic                       cmd_valid,
  input logic                       cmd_ready,
  input logic                       res_valid,
  input logic                       res_ready,
  input logic signed [SAMPLE_W-1:0] sample,
  input logic                       last,
  input logic                       done_res
);

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = SAMPLE_W'(SCALE_K);

  // A stalled word holds.
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(sample) && $stable(last)
      && $stable(done_res))
    else $error("result word changed while stalled");

  // An ended sound reports silence and no last flag.
  a_done_silent: assert property (@(posedge clk) disable iff (rst)
    res_valid && done_res |-> sample == '0 && !last)
    else $error("done word carries a sample or last flag");

  // The block works on one command at a time.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready |=> !cmd_ready)
    else $error("command taken while previous one is in progress");

  // Samples stay inside the scaled full range.
  a_sample_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> sample <= SAMPLE_MAX && sample >= -SAMPLE_MAX)
    else $error("sample out of range");

  // Reset leaves the block empty and ready.
  a_reset_state: assert property (@(posedge clk)
    rst |=> !res_valid && cmd_ready)
    else $error("block not idle after reset");

endmodule

bind noise_chirp_sound_synth ncs_checker u_ncs_checker (.*);

// ----- sim/tb.sv -----
`timescale 1ns / 1ps

module tb;
  import ncs_pkg::*;

  // Clock period halves and the wait after the last word, which is long enough
  // that the block has nothing left in flight.
  localparam int CLK_HALF_NS  = 6;
  localparam int SETTLE_CYCLES = 16;
  localparam int RANDOM_WORDS  = 1950;
  localparam int IDLE_PCT      = 29;

  // Index 7 is not a register; writes to it must be dropped.
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

  // Fixed-point constants of the synthesizer, written out here on purpose so the
  // predictor does not lean on the design's own package values.
  localparam logic [31:0] NOISE_MUL  = 32'd1664525;
  localparam logic [31:0] NOISE_ADD  = 32'd1013904223;
  localparam longint      NOISE_MIX  = 157286;
  localparam longint      SINE_MIX   = 39322;
  localparam longint      FULL_SCALE = 64'sh0000_8000_0000_0000;
  localparam longint      OUT_SCALE  = 32000;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [31:0] DECAY_ONE  = 32'h0100_0000;
  localparam logic [31:0] ATTACK_ONE = 32'h0001_0000;

  // One result word as the block returns it.
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last;
    logic                       done;
  } word_t;

  // The sound state that a restart reloads.
  typedef struct {
    logic [31:0] noise;
    int          lp;
    logic [31:0] phase;
    logic [31:0] step;
    logic [31:0] decay;
    logic [31:0] attack;
    logic [19:0] index;
  } voice_t;

  // One line of the directed plan: either a register write or a command word.
  typedef enum logic { ROW_CMD, ROW_CFG } row_kind_t;

  typedef struct {
    row_kind_t             kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_W-1:0]      data;
    logic                  rs;
    logic                  typed;
    word_t                 want;
  } row_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]       cfg_index = '0;
  logic [CFG_W-1:0]           cfg_data = '0;
  logic                       cmd_valid = 1'b0;
  logic                       cmd_ready;
  logic                       restart = 1'b0;
  logic                       res_valid;
  logic                       res_ready = 1'b0;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       last;
  logic                       done_res;

  noise_chirp_sound_synth u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .restart   (restart),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .sample    (sample),
    .last      (last),
    .done_res  (done_res)
  );

  always begin
    #CLK_HALF_NS clk = 1'b1;
    #CLK_HALF_NS clk = 0;
  end

  // Shadow copy of the registers and of the sound state, plus the words that
  // the block still owes us, oldest first.
  cfg_t   regs;
  voice_t voice;
  int     sine_tab [SINE_TABLE_DEPTH];
  word_t  expected_samples [$];
  word_t  oldest;
  int     mismatches = 0;
  int     cmd_idle_pct = IDLE_PCT;
  int     res_idle_pct = IDLE_PCT;
  row_t   plan [$];

  // Full-wave sine entry in Q1.15. The angle is folded into the first
  // quadrant, a Taylor series to the x^13 term is summed in Q30, and the
  // result is rounded half up and held below one.
  function automatic int sine_value(input int k);
    logic [63:0]        t;
    logic [63:0]        r;
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    logic [63:0]        mag;
    logic [1:0]         quad;
    t    = (64'(k) << 32) / 64'(SINE_TABLE_DEPTH);
    quad = t[31:30];
    r    = t & 64'h3FFF_FFFF;
    if (quad[0]) begin
      r = 64'h4000_0000 - r;
    end
    x    = (r * HALF_PI_Q30) >> 30;
    x2   = (x * x) >> 30;
    term = x;
    sum  = $signed(x);
    for (int n = 1; n <= 6; n++) begin
      term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) begin
        sum = sum - $signed(term);
      end else begin
        sum = sum + $signed(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    mag = ($unsigned(sum) + 64'd16384) >> 15;
    if (mag > 64'd32767) begin
      mag = 64'd32767;
    end
    return quad[1] ? -int'(mag) : int'(mag);
  endfunction

  function automatic void reload_voice();
    voice.noise  = regs.noise_seed;
    voice.lp     = 0;
    voice.phase  = '0;
    voice.step   = 32'(regs.start_phase_step);
    voice.decay  = DECAY_ONE;
    voice.attack = '0;
    voice.index  = '0;
  endfunction

  // Works out the word that one command produces and advances the shadow
  // sound state the same way the block must.
  function automatic word_t synth_next_sample(input logic rs);
    word_t       w;
    int          noise;
    int          s;
    longint      gain;
    longint      diff;
    longint      lpl;
    longint      sl;
    longint      mix;
    longint      env;
    longint      v;
    longint      q;
    logic        neg;
    logic [63:0] pidx;
    logic [63:0] dprod;
    w = '0;
    if (rs) begin
      reload_voice();
    end
    // A finished sound, or a zero length, answers done and keeps its state.
    if (32'(voice.index) >= 32'(regs.sample_count)) begin
      w.done = 1'b1;
      return w;
    end
    voice.noise = voice.noise * NOISE_MUL + NOISE_ADD;
    noise       = voice.noise[31:8];
    noise       = noise - 8388608;
    gain        = regs.lowpass_gain;
    diff        = longint'(noise) - longint'(voice.lp);
    voice.lp    = voice.lp + int'((gain * diff) >>> 16);

    voice.phase = voice.phase + voice.step;
    pidx        = ({32'b0, voice.phase} * 64'(SINE_TABLE_DEPTH)) >> 32;
    s           = sine_tab[int'(pidx)];

    lpl = voice.lp;
    sl  = s;
    mix = (lpl * NOISE_MIX + sl * 256 * SINE_MIX) >>> 16;
    env = (longint'(voice.decay) * longint'(voice.attack)) >>> 16;
    v   = mix * env;
    if (v > FULL_SCALE) begin
      v = FULL_SCALE;
    end
    if (v < -FULL_SCALE) begin
      v = -FULL_SCALE;
    end
    neg = (v < 0);
    q   = ((neg ? -v : v) * OUT_SCALE) >>> 47;
    if (neg) begin
      q = -q;
    end
    w.sample = 16'(q);
    w.last   = ((32'(voice.index) + 32'd1) == 32'(regs.sample_count));

    // The sweep stops at zero rather than wrapping.
    if (voice.step > 32'(regs.sweep_step)) begin
      voice.step = voice.step - 32'(regs.sweep_step);
    end else begin
      voice.step = '0;
    end
    dprod        = 64'(voice.decay) * 64'(regs.decay_factor);
    voice.decay  = 32'(dprod >> 24);
    voice.attack = voice.attack + 32'(regs.attack_step);
    if (voice.attack > ATTACK_ONE) begin
      voice.attack = ATTACK_ONE;
    end
    voice.index = voice.index + 20'd1;
    return w;
  endfunction

  function automatic void check_field(input string name, input longint want,
                                      input longint got);
    if (want != got) begin
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // Receiver: every accepted word is held against the oldest expectation,
  // and ready drops at random so stalls land on every step of the block.
  always @(posedge clk) begin
    if (!rst && res_valid && res_ready) begin
      if (expected_samples.size() == 0) begin
        $display("%0t ns: unexpected word, sample %0d, last %0b, done %0b",
                 $time, sample, last, done_res);
        mismatches++;
      end else begin
        oldest = expected_samples.pop_front();
        check_field("sample", longint'($signed(oldest.sample)), longint'($signed(sample)));
        check_field("last", longint'(oldest.last), longint'(last));
        check_field("done_res", longint'(oldest.done), longint'(done_res));
      end
    end
    res_ready <= ($urandom_range(99) >= res_idle_pct);
  end

  // Register write on the plain port. The enable is dropped and the task waits with it
  // low before it returns, so back-to-back writes never raise and lower it in one step.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_SAMPLE_COUNT: regs.sample_count     = data[COUNT_W-1:0];
      CFG_NOISE_SEED:   regs.noise_seed       = data[SEED_W-1:0];
      CFG_LOWPASS_GAIN: regs.lowpass_gain     = data[GAIN_W-1:0];
      CFG_START_STEP:   regs.start_phase_step = data[PSTEP_W-1:0];
      CFG_SWEEP_STEP:   regs.sweep_step       = data[SWEEP_W-1:0];
      CFG_DECAY_FACTOR: regs.decay_factor     = data[DFAC_W-1:0];
      CFG_ATTACK_STEP:  regs.attack_step      = data[ATK_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Sends one command word. Valid is lowered only during an idle gap or a drain
  // and is otherwise kept high from one word to the next. The expectation is queued
  // at the edge where the word is taken.
  task automatic send_cmd(input logic rs, input logic typed, input word_t typed_word);
    word_t w;
    while ($urandom_range(99) < cmd_idle_pct) begin
      cmd_valid <= 1'b0;
      @(posedge clk);
    end
    cmd_valid <= 1'b1;
    restart   <= rs;
    @(posedge clk);
    while (!cmd_ready) begin
      @(posedge clk);
    end
    w = synth_next_sample(rs);
    if (typed) begin
      w = typed_word;
    end
    expected_samples = {expected_samples, w};
  endtask

  // Holds the command side off until every word owed has come back.
  task automatic drain_results();
    cmd_valid <= 1'b0;
    @(posedge clk);
    while (expected_samples.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // Drained and settled: the only time registers are touched.
  task automatic quiesce();
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Appends one line to the directed plan.
  function automatic void add_row(input row_t r);
    plan = {plan, r};
  endfunction

  function automatic row_t cfg_row(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    row_t r;
    r = '{ROW_CFG, idx, data, 1'b0, 1'b0, '0};
    return r;
  endfunction

  function automatic row_t cmd_row(input logic rs);
    row_t r;
    r = '{ROW_CMD, '0, '0, rs, 1'b0, '0};
    return r;
  endfunction

  function automatic row_t cmd_typed(input logic rs, input logic signed [15:0] smp,
                                     input logic lst, input logic dn);
    row_t r;
    r = '{ROW_CMD, '0, '0, rs, 1'b1, '{smp, lst, dn}};
    return r;
  endfunction

  // Extreme low, extreme high, or the typical value handed in.
  function automatic logic [31:0] pick(input logic [31:0] top, input logic [31:0] typical);
    case ($urandom_range(5))
      0:       return 32'd0;
      1:       return top;
      default: return typical;
    endcase
  endfunction

  // New settings for a random phase. Each register is rewritten about half
  // the time; typical values keep the sound audible and the lengths short so
  // that last and done words come often. Full 32-bit data sometimes carries
  // junk above the register width.
  task automatic random_config();
    if ($urandom_range(1)) begin
      write_reg(CFG_SAMPLE_COUNT, pick(32'hF_FFFF,
                ($urandom_range(4) == 0) ? $urandom : $urandom_range(1, 48)));
    end
    if ($urandom_range(1)) begin
      write_reg(CFG_NOISE_SEED, pick(32'hFFFF_FFFF, $urandom));
    end
    if ($urandom_range(1)) begin
      write_reg(CFG_LOWPASS_GAIN, pick(32'hFFFF, $urandom));
    end
    if ($urandom_range(1)) begin
      write_reg(CFG_START_STEP, pick(32'h7FFF_FFFF,
                $urandom_range(1) ? $urandom : $urandom_range(0, 30000000)));
    end
    if ($urandom_range(1)) begin
      write_reg(CFG_SWEEP_STEP, pick(32'hFFFF,
                $urandom_range(1) ? $urandom : $urandom_range(0, 2000)));
    end
    if ($urandom_range(1)) begin
      write_reg(CFG_DECAY_FACTOR, pick(32'hFF_FFFF,
                $urandom_range(2) == 0 ? $urandom : 32'hFF_FFFF - $urandom_range(0, 20000)));
    end
    if ($urandom_range(1)) begin
      write_reg(CFG_ATTACK_STEP, pick(32'h1_0000,
                $urandom_range(1) ? $urandom : $urandom_range(0, 70000)));
    end
    if ($urandom_range(7) == 0) begin
      write_reg(CFG_UNUSED, $urandom);
    end
  endtask

  initial begin
    int    sent;
    int    quota;
    int    phase_no;
    int    n;
    logic  rs;

    for (int k = 0; k < SINE_TABLE_DEPTH; k++) begin
      sine_tab[k] = sine_value(k);
    end
    // Register values after reset.
    regs.sample_count     = 20'd70560;
    regs.noise_seed       = 32'd1;
    regs.lowpass_gain     = 16'd7864;
    regs.start_phase_step = 31'd4674794;
    regs.sweep_step       = 16'd33;
    regs.decay_factor     = 24'd16776075;
    regs.attack_step      = 17'd594;
    reload_voice();

    // Directed plan. Sample zero always has a zero attack, so it is silent;
    // short and zero-length sounds have words that can be read off directly.
    // The rest are checked against the predictor.
    add_row(cmd_typed(1'b0, 16'sd0, 1'b0, 1'b0));  // first advance after reset
    add_row(cmd_row(1'b0));
    add_row(cmd_row(1'b0));
    // Ramp reaches one in a single step, noise filter nearly unfiltered,
    // decay as slow as it gets.
    add_row(cfg_row(CFG_ATTACK_STEP, 32'h1_0000));
    add_row(cfg_row(CFG_LOWPASS_GAIN, 32'hFFFF));
    add_row(cfg_row(CFG_DECAY_FACTOR, 32'hFF_FFFF));
    add_row(cmd_typed(1'b1, 16'sd0, 1'b0, 1'b0));
    add_row(cmd_row(1'b0));
    add_row(cmd_row(1'b0));
    // Attack step above one must still saturate; the sweep runs the phase
    // increment into zero within two samples.
    add_row(cfg_row(CFG_ATTACK_STEP, 32'h1_FFFF));
    add_row(cfg_row(CFG_START_STEP, 32'd100000));
    add_row(cfg_row(CFG_SWEEP_STEP, 32'hFFFF));
    add_row(cfg_row(CFG_NOISE_SEED, 32'hFFFF_FFFF));
    add_row(cmd_typed(1'b1, 16'sd0, 1'b0, 1'b0));
    add_row(cmd_row(1'b0));
    add_row(cmd_row(1'b0));
    add_row(cmd_row(1'b0));
    // Opposite extremes: fastest oscillator, no sweep, frozen filter, and an
    // envelope that collapses after the first sample.
    add_row(cfg_row(CFG_START_STEP, 32'h7FFF_FFFF));
    add_row(cfg_row(CFG_SWEEP_STEP, 32'd0));
    add_row(cfg_row(CFG_LOWPASS_GAIN, 32'd0));
    add_row(cfg_row(CFG_DECAY_FACTOR, 32'd0));
    add_row(cfg_row(CFG_NOISE_SEED, 32'd0));
    add_row(cmd_typed(1'b1, 16'sd0, 1'b0, 1'b0));
    add_row(cmd_row(1'b0));
    add_row(cmd_row(1'b0));
    // A zero-length sound is done on every word, restart included.
    add_row(cfg_row(CFG_SAMPLE_COUNT, 32'd0));
    add_row(cmd_typed(1'b1, 16'sd0, 1'b0, 1'b1));
    add_row(cmd_typed(1'b0, 16'sd0, 1'b0, 1'b1));
    // One-sample sound: sample zero is also the last, then done.
    add_row(cfg_row(CFG_SAMPLE_COUNT, 32'd1));
    add_row(cmd_typed(1'b1, 16'sd0, 1'b1, 1'b0));
    add_row(cmd_typed(1'b0, 16'sd0, 1'b0, 1'b1));
    // The length is compared live: stretching it lets the ended sound resume.
    add_row(cfg_row(CFG_SAMPLE_COUNT, 32'd3));
    add_row(cmd_row(1'b0));
    add_row(cmd_row(1'b0));
    add_row(cmd_typed(1'b0, 16'sd0, 1'b0, 1'b1));
    // A write to the unused index changes nothing.
    add_row(cfg_row(CFG_UNUSED, 32'hA5C3_0F96));
    add_row(cmd_typed(1'b0, 16'sd0, 1'b0, 1'b1));
    add_row(cfg_row(CFG_SAMPLE_COUNT, 32'hF_FFFF));
    add_row(cmd_typed(1'b1, 16'sd0, 1'b0, 1'b0));
    add_row(cmd_row(1'b0));

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        quiesce();
        write_reg(plan[i].idx, plan[i].data);
      end else begin
        send_cmd(plan[i].rs, plan[i].typed, plan[i].want);
      end
    end

    // Random phases. Each one takes new settings while the block is idle and
    // then mostly plays whole sounds: a restart, a run of advances to and past
    // the end, and a restart again a little after done. Stray restarts inside
    // a sound and now and then a phase that just continues the old sound
    // under new settings make up the noise. Phase four runs without any idling.
    sent     = 0;
    phase_no = 0;
    while (sent < RANDOM_WORDS) begin
      phase_no++;
      quiesce();
      if (phase_no == 4) begin
        cmd_idle_pct = 0;
        res_idle_pct = 0;
      end else begin
        cmd_idle_pct = IDLE_PCT;
        res_idle_pct = IDLE_PCT;
      end
      random_config();
      quota = (phase_no == 4) ? 200 : $urandom_range(30, 90);
      n     = 0;
      if ($urandom_range(4) != 0) begin
        send_cmd(1'b1, 1'b0, '0);
        n++;
      end
      while (n < quota) begin
        if (32'(voice.index) >= 32'(regs.sample_count)) begin
          rs = ($urandom_range(2) == 0);
        end else begin
          rs = ($urandom_range(99) < 3);
        end
        send_cmd(rs, 1'b0, '0);
        n++;
        // Now and then the sender waits for every owed word mid-stream.
        if ($urandom_range(49) == 0) begin
          drain_results();
        end
      end
      sent = sent + n;
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("** noise_chirp_sound_synth: PASSED **");
    end else begin
      $display("** noise_chirp_sound_synth: FAILED **");
    end
    $finish;
  end

  // Watchdog, many times the slowest correct run.
  initial begin
    #10_000_000;
    $display("** noise_chirp_sound_synth: FAILED **");
    $finish;
  end

endmodule
